### sv/pes_pkg.sv
package pes_pkg;

   localparam logic [1:0] STATUS_DATA     = 2'd0;
   localparam logic [1:0] STATUS_DONE     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_NUL        = 8'h00;

   // bytes that must be left for the escape plus terminator before encoding
   localparam int unsigned HEADROOM       = 4;
   localparam int unsigned DST_CAP_WIDTH  = 16;
   localparam int unsigned RESULT_DEPTH   = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       run_end;
   } result_type;

   function automatic logic is_unreserved(input logic [7:0] b);
      logic hit;
      hit = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                       8'h2D, 8'h2E, 8'h5F, 8'h7E});
      return hit;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 4'd10) begin
         ch = 8'h30 + {4'b0000, v};
      end else begin
         ch = 8'h37 + {4'b0000, v};
      end
      return ch;
   endfunction

endpackage

### sv/percent_encoder_stream.sv
// URI percent-encoder, one source byte per req beat, one encoded character per
// rsp beat. Letters, digits and - . _ ~ pass through as one beat; any other
// byte goes out as '%' plus two upper-case hex digits (three beats); the last
// byte of a good string adds a NUL beat with status done. When the output
// count plus 4 reaches csr capacity, a single overflow beat is sent and the
// rest of the string, up to its last byte, is swallowed without results.
// Timing: a req beat is encoded in the cycle it is taken and its results are
// loaded into a 4-entry result shift register that drains one rsp beat per
// cycle while rsp_ready is high. A new req beat is taken as soon as that
// register is empty or is giving up its final entry. An item yields one
// result for a pass-through byte, three for an escaped byte, plus one for a
// terminator, and none for a dropped byte. The first rsp beat of an item is
// valid in the cycle after its req beat is taken. No clearing pass after reset.
module percent_encoder_stream
   import pes_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_src_byte,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic [1:0]               rsp_status,
   output logic                     rsp_run_end,
   input  logic                     csr_wr_en,
   input  logic [DST_CAP_WIDTH-1:0] csr_wr_data
);

   localparam int unsigned CMP_WIDTH =
      ((COUNT_WIDTH > DST_CAP_WIDTH) ? COUNT_WIDTH : DST_CAP_WIDTH) + 1;
   localparam int unsigned REM_WIDTH = $clog2(RESULT_DEPTH + 1);

   logic [DST_CAP_WIDTH-1:0] cap_ff,   cap_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     ovf_ff,   ovf_in;
   logic [REM_WIDTH-1:0]     rem_ff,   rem_in;
   result_type               res_ff [RESULT_DEPTH];
   result_type               res_in [RESULT_DEPTH];

   result_type               new_res [RESULT_DEPTH];
   logic [REM_WIDTH-1:0]     new_n;
   logic [COUNT_WIDTH-1:0]   new_count;
   logic                     new_ovf;
   logic                     cap_hit;
   logic [COUNT_WIDTH:0]     count_sum;
   logic [COUNT_WIDTH-1:0]   count_sat;
   logic                     unres;
   logic                     req_fire;
   logic                     rsp_fire;

   assign rsp_valid    = (rem_ff != '0);
   assign rsp_out_byte = res_ff[0].out_byte;
   assign rsp_status   = res_ff[0].status;
   assign rsp_run_end  = res_ff[0].run_end;
   assign rsp_fire     = rsp_valid && rsp_ready;
   // take the next beat once the buffer is empty or about to be
   assign req_ready    = (rem_ff == '0) || ((rem_ff == REM_WIDTH'(1)) && rsp_ready);
   assign req_fire     = req_valid && req_ready;

   assign cap_hit = (CMP_WIDTH'(count_ff) + CMP_WIDTH'(HEADROOM)) >= CMP_WIDTH'(cap_ff);
   assign unres   = is_unreserved(req_src_byte);

   always_comb begin
      count_sum = {1'b0, count_ff} + (unres ? (COUNT_WIDTH+1)'(1) : (COUNT_WIDTH+1)'(3));
      count_sat = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
   end

   // encode the incoming beat into up to four results
   always_comb begin
      for (int i = 0; i < RESULT_DEPTH; i++) begin
         new_res[i] = '{out_byte: CHAR_NUL, status: STATUS_DATA, run_end: 1'b0};
      end
      new_n     = '0;
      new_count = count_ff;
      new_ovf   = ovf_ff;
      if (ovf_ff) begin
         if (req_last_byte) begin
            new_ovf   = 1'b0;
            new_count = '0;
         end
      end else if (cap_hit) begin
         new_res[0] = '{out_byte: CHAR_NUL, status: STATUS_OVERFLOW, run_end: 1'b1};
         new_n      = REM_WIDTH'(1);
         new_ovf    = !req_last_byte;
         if (req_last_byte) begin
            new_count = '0;
         end
      end else if (unres) begin
         new_res[0].out_byte = req_src_byte;
         new_count           = req_last_byte ? '0 : count_sat;
         if (req_last_byte) begin
            new_res[1] = '{out_byte: CHAR_NUL, status: STATUS_DONE, run_end: 1'b1};
            new_n      = REM_WIDTH'(2);
         end else begin
            new_res[0].run_end = 1'b1;
            new_n              = REM_WIDTH'(1);
         end
      end else begin
         new_res[0].out_byte = CHAR_PERCENT;
         new_res[1].out_byte = hex_digit(req_src_byte[7:4]);
         new_res[2].out_byte = hex_digit(req_src_byte[3:0]);
         new_count           = req_last_byte ? '0 : count_sat;
         if (req_last_byte) begin
            new_res[3] = '{out_byte: CHAR_NUL, status: STATUS_DONE, run_end: 1'b1};
            new_n      = REM_WIDTH'(4);
         end else begin
            new_res[2].run_end = 1'b1;
            new_n              = REM_WIDTH'(3);
         end
      end
   end

   always_comb begin
      cap_in   = csr_wr_en ? csr_wr_data : cap_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      if (rsp_fire) begin
         for (int i = 0; i < RESULT_DEPTH - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         rem_in = rem_ff - REM_WIDTH'(1);
      end
      // only taken when the buffer is empty or drains this cycle, so a plain overwrite
      if (req_fire) begin
         res_in   = new_res;
         rem_in   = new_n;
         count_in = new_count;
         ovf_in   = new_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= '1;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         rem_ff   <= '0;
      end else begin
         cap_ff   <= cap_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

### sv/pes_checker.sv
module pes_checker
   import pes_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [1:0]  rsp_status,
   input logic        rsp_run_end
);

   // a pending rsp beat is held until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status))
      else $error("rsp beat dropped or changed while stalled");

   // done and overflow beats are always the closing beat of their item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DONE || rsp_status == STATUS_OVERFLOW)
      |-> rsp_run_end && rsp_out_byte == CHAR_NUL)
      else $error("status beat not a NUL run end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_DATA || rsp_status == STATUS_DONE ||
                    rsp_status == STATUS_OVERFLOW)
      else $error("illegal rsp status");

   // an item's results come out without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_end |=> rsp_valid)
      else $error("gap inside an item's results");

   // no new req beat while more than the last result is still queued
   assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_ready && rsp_run_end)
      else $error("req taken while results still pending");

endmodule

bind percent_encoder_stream pes_checker u_pes_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_status   (rsp_status),
   .rsp_run_end  (rsp_run_end)
);
